@@ src/laser_scan_polar_projector_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LASER_SCAN_POLAR_PROJECTOR_MACROS_SVH
`define LASER_SCAN_POLAR_PROJECTOR_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define LSPP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition that must hold in the cycle after its trigger.
`define LSPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lspp_pkg.sv @@
package lspp_pkg;

    // Rotation depth and sample index width
    localparam int CORDIC_ITERATIONS = 20;
    localparam int INDEX_BITS        = 16;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

    // Datapath widths: Q8.24 rotation registers with headroom, angle accumulator
    localparam int RANGE_W = 24;
    localparam int COORD_W = 25;
    localparam int ANGLE_W = 32;
    localparam int XW      = 35;
    localparam int ZW      = 34;
    localparam int PROD_W  = RANGE_W + 32;

    // CORDIC gain 0.607... in Q0.32, output saturation bound
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
    localparam int SAT_LIMIT = 16777215;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_RANGE    = 3'd0;
    localparam t_cfg_idx CFG_MAX_RANGE    = 3'd1;
    localparam t_cfg_idx CFG_SENSOR_MIN   = 3'd2;
    localparam t_cfg_idx CFG_SENSOR_MAX   = 3'd3;
    localparam t_cfg_idx CFG_ANGLE_START  = 3'd4;
    localparam t_cfg_idx CFG_ANGLE_STEP   = 3'd5;
    localparam t_cfg_idx CFG_KEEP_STRIDE  = 3'd6;

    typedef logic [RANGE_W-1:0]        t_range;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic [15:0]               t_index;

    // Request from the control logic to the rotation unit
    typedef struct packed {
        logic   start;
        t_range range;
        t_angle angle;
        logic   out_free;
    } t_cordic_req;

    // Finished rotation, valid for one cycle
    typedef struct packed {
        logic   done;
        t_coord x;
        t_coord y;
    } t_cordic_rsp;

    // Arctangent of 2^-i in binary angle units, full turn = 2^32
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Clamp a rounded coordinate to the symmetric output range
    function automatic t_coord sat_coord(logic signed [XW-1:0] v);
        logic signed [XW-1:0] lim;
        lim = XW'(SAT_LIMIT);
        if (v > lim) begin
            return COORD_W'(SAT_LIMIT);
        end else if (v < -lim) begin
            return -COORD_W'(SAT_LIMIT);
        end
        return COORD_W'(v);
    endfunction

endpackage

@@ src/lspp_if.sv @@
// Range sample channel
interface lspp_sample_if;
    import lspp_pkg::*;
    logic   valid;
    logic   ready;
    t_range range_sample;
    logic   sample_finite;
    logic   scan_start;

    modport source(output valid, range_sample, sample_finite, scan_start, input ready);
    modport sink(input valid, range_sample, sample_finite, scan_start, output ready);
endinterface

// Projected point channel
interface lspp_point_if;
    import lspp_pkg::*;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_index sample_index;
    t_range point_range;

    modport source(output valid, point_x, point_y, sample_index, point_range, input ready);
    modport sink(input valid, point_x, point_y, sample_index, point_range, output ready);
endinterface

@@ src/lspp_cordic.sv @@
module lspp_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lspp_pkg::t_cordic_req i_req,
    output lspp_pkg::t_cordic_rsp o_rsp
);
    import lspp_pkg::*;

    typedef enum logic [3:0] {
        CS_IDLE  = 4'b0001,
        CS_SCALE = 4'b0010,
        CS_ITER  = 4'b0100,
        CS_FINAL = 4'b1000
    } t_cs_state;

    t_cs_state             r_state;
    t_cs_state             n_state;
    t_range                r_range;
    logic                  r_flip;
    logic [ITER_W-1:0]     r_iter;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [ZW-1:0]  r_z;

    logic [PROD_W-1:0]     scale_prod;
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic signed [ZW-1:0]  atan_step;
    logic                  last_iter;
    logic signed [XW-1:0]  x_rnd;
    logic signed [XW-1:0]  y_rnd;
    logic signed [XW-1:0]  x_fin;
    logic signed [XW-1:0]  y_fin;

    // Shared multiply for gain scaling and shared shift/add stage for rotation
    assign scale_prod = PROD_W'(r_range) * PROD_W'(GAIN_Q32);
    assign dx         = r_y >>> r_iter;
    assign dy         = r_x >>> r_iter;
    assign atan_step  = ZW'(ATAN_TURN[5'(r_iter)]);
    assign last_iter  = (r_iter == ITER_W'(CORDIC_ITERATIONS - 1));

    // Round Q8.24 to Q8.16, undo the half turn, clamp
    assign x_rnd = (r_x + XW'(128)) >>> 8;
    assign y_rnd = (r_y + XW'(128)) >>> 8;
    assign x_fin = r_flip ? -x_rnd : x_rnd;
    assign y_fin = r_flip ? -y_rnd : y_rnd;

    assign o_rsp.done = (r_state == CS_FINAL) && i_req.out_free;
    assign o_rsp.x    = sat_coord(x_fin);
    assign o_rsp.y    = sat_coord(y_fin);

    // Sequence: load, scale, iterate, hand over
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:  if (i_req.start) n_state = CS_SCALE;
            CS_SCALE: n_state = CS_ITER;
            CS_ITER:  if (last_iter) n_state = CS_FINAL;
            CS_FINAL: if (i_req.out_free) n_state = CS_IDLE;
            default:  n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_IDLE: begin
                if (i_req.start) begin
                    // Fold angles in the left half plane by a half turn
                    r_range <= i_req.range;
                    r_flip  <= i_req.angle[31] ^ i_req.angle[30];
                    r_z     <= ZW'(signed'({i_req.angle[30], i_req.angle[30:0]}));
                end
            end
            CS_SCALE: begin
                r_x    <= XW'(scale_prod >> 24);
                r_y    <= '0;
                r_iter <= '0;
            end
            CS_ITER: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_step;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_step;
                end
                if (!last_iter) begin
                    r_iter <= r_iter + 1'b1;
                end
            end
            CS_FINAL: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ src/laser_scan_polar_projector.sv @@
// A kept sample reaches o_point after its transaction by way of the gain multiply, the
// rotation iterations and the output load. The shared rotation unit takes one kept
// sample at a time and the input is not ready again until it hands the point over,
// which waits while o_point stalls; a dropped sample leaves the input ready.
// Reset (synchronous, active low): configuration registers return to their defaults,
// index, phase and beam angle clear, and any pending point is discarded.
module laser_scan_polar_projector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  lspp_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    lspp_sample_if.sink        i_sample,
    lspp_point_if.source       o_point
);
    import lspp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    // Configuration registers
    t_range      r_min_range;
    t_range      r_max_range;
    t_range      r_sensor_min;
    t_range      r_sensor_max;
    t_angle      r_angle_start;
    t_angle      r_angle_step;
    logic [15:0] r_stride;

    // Derived window and validity, decoded straight off the configuration
    t_range      eff_min;
    t_range      eff_max;
    logic        cfg_ok;

    // Scan state
    t_state                r_state;
    t_angle                r_angle;
    logic [INDEX_BITS-1:0] r_index;
    logic [15:0]           r_phase;

    // Job and output registers
    t_index r_job_index;
    t_range r_job_range;
    logic   r_out_valid;
    t_coord r_out_x;
    t_coord r_out_y;
    t_index r_out_index;
    t_range r_out_range;

    logic                  accept;
    logic                  keep;
    t_angle                angle_sel;
    logic [INDEX_BITS-1:0] index_sel;
    logic [15:0]           phase_sel;
    logic [16:0]           phase_inc;
    t_angle                n_angle;
    logic [INDEX_BITS-1:0] n_index;
    logic [15:0]           n_phase;
    t_cordic_req           cordic_req;
    t_cordic_rsp           cordic_rsp;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign accept         = i_sample.valid && i_sample.ready;

    // Tighter of user and sensor limits, and the overall validity flag
    assign eff_min = (r_min_range > r_sensor_min) ? r_min_range : r_sensor_min;
    assign eff_max = (r_max_range < r_sensor_max) ? r_max_range : r_sensor_max;
    assign cfg_ok  = (r_angle_step != '0) && (r_max_range > r_min_range) &&
                     (r_sensor_max > r_sensor_min) && (r_stride != '0) &&
                     (eff_min <= eff_max);

    // Restart index, phase and angle on the first sample of a scan
    assign angle_sel = i_sample.scan_start ? r_angle_start : r_angle;
    assign index_sel = i_sample.scan_start ? '0 : r_index;
    assign phase_sel = i_sample.scan_start ? '0 : r_phase;

    assign keep = cfg_ok && (phase_sel == '0) && i_sample.sample_finite &&
                  (i_sample.range_sample >= eff_min) &&
                  (i_sample.range_sample <= eff_max);

    // Advance to the next sample
    assign phase_inc = {1'b0, phase_sel} + 17'd1;
    assign n_phase   = (phase_inc >= {1'b0, r_stride}) ? '0 : phase_inc[15:0];
    assign n_index   = index_sel + 1'b1;
    assign n_angle   = angle_sel + r_angle_step;

    assign cordic_req.start    = accept && keep;
    assign cordic_req.range    = i_sample.range_sample;
    assign cordic_req.angle    = angle_sel;
    assign cordic_req.out_free = !r_out_valid || o_point.ready;

    lspp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range   <= '0;
            r_max_range   <= '1;
            r_sensor_min  <= '0;
            r_sensor_max  <= '1;
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_stride      <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_RANGE:    r_min_range   <= i_cfg_data[RANGE_W-1:0];
                CFG_MAX_RANGE:    r_max_range   <= i_cfg_data[RANGE_W-1:0];
                CFG_SENSOR_MIN:   r_sensor_min  <= i_cfg_data[RANGE_W-1:0];
                CFG_SENSOR_MAX:   r_sensor_max  <= i_cfg_data[RANGE_W-1:0];
                CFG_ANGLE_START:  r_angle_start <= i_cfg_data;
                CFG_ANGLE_STEP:   r_angle_step  <= i_cfg_data;
                CFG_KEEP_STRIDE:  r_stride      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Scan counters and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_angle <= '0;
            r_index <= '0;
            r_phase <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_angle <= n_angle;
                        r_index <= n_index;
                        r_phase <= n_phase;
                        if (keep) begin
                            r_state <= ST_BUSY;
                        end
                    end
                end
                ST_BUSY: begin
                    if (cordic_rsp.done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold index and range of the sample under rotation
    always_ff @(posedge i_clk) begin
        if (cordic_req.start) begin
            r_job_index <= 16'(index_sel);
            r_job_range <= i_sample.range_sample;
        end
    end

    // Output register: load on a finished rotation, drop on a taken transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cordic_rsp.done) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cordic_rsp.done) begin
            r_out_x     <= cordic_rsp.x;
            r_out_y     <= cordic_rsp.y;
            r_out_index <= r_job_index;
            r_out_range <= r_job_range;
        end
    end

    assign o_point.valid        = r_out_valid;
    assign o_point.point_x      = r_out_x;
    assign o_point.point_y      = r_out_y;
    assign o_point.sample_index = r_out_index;
    assign o_point.point_range  = r_out_range;

endmodule

@@ src/lspp_checker.sv @@
`include "laser_scan_polar_projector_macros.svh"

module lspp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_finite,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input lspp_pkg::t_coord i_out_x,
    input lspp_pkg::t_coord i_out_y,
    input lspp_pkg::t_index i_out_index,
    input lspp_pkg::t_range i_out_range
);
    import lspp_pkg::*;

    logic in_take;
    logic out_stall;
    logic out_in_range;

    assign in_take      = i_in_valid && i_in_ready;
    assign out_stall    = i_out_valid && !i_out_ready;
    assign out_in_range = (i_out_x != t_coord'(1 << (COORD_W - 1))) &&
                          (i_out_y != t_coord'(1 << (COORD_W - 1)));

    // A stalled point keeps its valid and payload
    `LSPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_index) && $stable(i_out_range), "stalled point changed")

    // A non-finite sample is dropped and the block stays ready
    `LSPP_ASSERT_NEXT(a_drop_ready, i_clk, i_rst_n, in_take && !i_in_finite, i_in_ready, "dropped sample stalled the input")

    // Coordinates never reach the most negative code after saturation
    `LSPP_ASSERT_SAME(a_sat_bound, i_clk, i_rst_n, i_out_valid, out_in_range, "coordinate outside saturation bound")

endmodule

bind laser_scan_polar_projector lspp_checker u_lspp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_in_finite (i_sample.sample_finite),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_out_x     (o_point.point_x),
    .i_out_y     (o_point.point_y),
    .i_out_index (o_point.sample_index),
    .i_out_range (o_point.point_range)
);
